@@ rtl/core/mpphc_pkg.sv @@
package mpphc_pkg;

  localparam int MaxPanelsDefault = 8;
  localparam int RefStepDefault   = 8;

  localparam int SampleW  = 16;
  localparam int RefW     = 11;
  localparam int PanelW   = 3;
  localparam int NumW     = 4;
  localparam int PowerW   = 32;
  localparam int ReleaseW = 17;
  localparam int LimitW   = 24;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int SumW     = SampleW + NumW;
  localparam int NeedW    = 16;

  localparam logic [RefW-1:0] RefMax = 11'd2047;

  localparam logic [CfgIdxW-1:0] CfgNumPanels   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgVoltThr     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPowerThr    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCurrThr     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgReleaseThr  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRefSumLimit = 3'd5;

  localparam logic OpInit   = 1'b0;
  localparam logic OpUpdate = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RDP,
    S_INIT_WR,
    S_CALC1,
    S_CALC2,
    S_CALC3,
    S_RSCAN,
    S_RWAIT,
    S_NEED,
    S_DIV,
    S_EMIT0,
    S_ADJ_RD,
    S_ADJ_WR
  } state_e;

  typedef struct packed {
    logic [SampleW-1:0] volt;
    logic [SampleW-1:0] curr;
    logic               mpp;
    logic               shade;
    logic [RefW-1:0]    refv;
  } panel_rec_t;

endpackage

@@ rtl/core/mpphc_in_if.sv @@
interface mpphc_in_if import mpphc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [PanelW-1:0]  panel_index;
  logic [SampleW-1:0] voltage_raw;
  logic [SampleW-1:0] current_raw;
  logic [RefW-1:0]    device_reference;
  logic               end_of_round;

  modport source (
    output valid, op, panel_index, voltage_raw, current_raw, device_reference, end_of_round,
    input  ready
  );
  modport sink (
    input  valid, op, panel_index, voltage_raw, current_raw, device_reference, end_of_round,
    output ready
  );
endinterface

@@ rtl/core/mpphc_out_if.sv @@
interface mpphc_out_if import mpphc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PanelW-1:0] out_panel;
  logic [RefW-1:0]   reference_value;
  logic              write_enable;
  logic              at_mpp;
  logic              shaded;
  logic              last;

  modport source (
    output valid, out_panel, reference_value, write_enable, at_mpp, shaded, last,
    input  ready
  );
  modport sink (
    input  valid, out_panel, reference_value, write_enable, at_mpp, shaded, last,
    output ready
  );
endinterface

@@ rtl/core/mpphc_mem.sv @@
module mpphc_mem import mpphc_pkg::*; #(
  parameter int DEPTH = MaxPanelsDefault,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output panel_rec_t    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  panel_rec_t    wr_data_i
);

  panel_rec_t mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  panel_rec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/mpphc_div.sv @@
module mpphc_div import mpphc_pkg::*; #(
  parameter int DW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NeedW-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  output logic [NeedW-1:0] quotient_o,
  output logic [DW-1:0]    remainder_o,
  output logic             done_o
);

  localparam int CntW = $clog2(NeedW);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [NeedW-1:0] quo_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    div_q;
  logic [DW:0]      trial;
  logic             ge;

  assign trial = {rem_q, quo_q[NeedW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NeedW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(trial - {1'b0, div_q}) : DW'(trial);
      quo_q <= {quo_q[NeedW-2:0], ge};
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

@@ rtl/core/multi_panel_mppt_hill_climb.sv @@
// Channel  Direction  Beat contents
// in_if    sink       op, panel_index, voltage_raw, current_raw, device_reference, end_of_round
// out_if   source     out_panel, reference_value, write_enable, at_mpp, shaded, last
// cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// One input beat is worked on at a time; every read goes through the single
// read port of the per-panel record memory. An update beat reads every panel in
// use, since the average current and the all-at-MPP test are read from memory
// one panel per cycle. At end of round the reference sum is read the same way,
// and if the limit is exceeded the serial divider runs, then each panel's
// reference is read, reduced and written back in turn.
// Reset clears the record memory valid bits at once; there is no clearing pass.
// A stalled output holds the sequencer at its next result; a new input beat is
// taken while the last result of the previous beat still waits to be taken.
module multi_panel_mppt_hill_climb import mpphc_pkg::*; #(
  parameter int MAX_PANELS = MaxPanelsDefault,
  parameter int REF_STEP   = RefStepDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  mpphc_in_if.sink            in_if,
  mpphc_out_if.source         out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int IW = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;
  localparam int CW = $clog2(MAX_PANELS + 1);
  localparam int RW = $clog2(int'(RefMax) + 1 + REF_STEP) + 1;

  logic [NumW-1:0]     num_panels_q;
  logic [SampleW-1:0]  volt_thr_q;
  logic [PowerW-1:0]   power_thr_q;
  logic [SampleW-1:0]  curr_thr_q;
  logic [ReleaseW-1:0] release_thr_q;
  logic [LimitW-1:0]   ref_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_panels_q  <= NumW'(1);
      volt_thr_q    <= '0;
      power_thr_q   <= '0;
      curr_thr_q    <= '0;
      release_thr_q <= '0;
      ref_limit_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNumPanels:   num_panels_q  <= cfg_data_i[NumW-1:0];
        CfgVoltThr:     volt_thr_q    <= cfg_data_i[SampleW-1:0];
        CfgPowerThr:    power_thr_q   <= cfg_data_i[PowerW-1:0];
        CfgCurrThr:     curr_thr_q    <= cfg_data_i[SampleW-1:0];
        CfgReleaseThr:  release_thr_q <= cfg_data_i[ReleaseW-1:0];
        CfgRefSumLimit: ref_limit_q   <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] n_active;

  always_comb begin
    if (num_panels_q == '0) begin
      n_active = CW'(1);
    end else if (6'(num_panels_q) > 6'(MAX_PANELS)) begin
      n_active = CW'(MAX_PANELS);
    end else begin
      n_active = CW'(num_panels_q);
    end
  end

  state_e state_q, state_d;

  logic               op_q;
  logic [PanelW-1:0]  p_q;
  logic [SampleW-1:0] v_q;
  logic [SampleW-1:0] c_q;
  logic [RefW-1:0]    dref_q;
  logic               eor_q;
  logic [CW-1:0]      n_q;
  logic [IW-1:0]      idx_q, idx_d;

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  panel_rec_t         rd_data;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  panel_rec_t         wr_data;

  logic               in_ready;
  logic               accept;
  logic               idx_last;
  logic               slot_free;
  logic               out_load;
  logic               out_valid_q;
  logic [PanelW-1:0]  ld_panel;
  logic [RefW-1:0]    ld_ref;
  logic               ld_we;
  logic               ld_mpp;
  logic               ld_sh;
  logic               ld_last;

  logic               acc_en_q;
  logic               acc_ref_q;
  logic [SumW-1:0]    acc_q;
  logic               all_mpp_q;

  panel_rec_t         rec_q;
  logic [PowerW-1:0]  prod_new_q;
  logic [PowerW-1:0]  prod_old_q;
  logic signed [SampleW:0] dv_q;
  logic [SumW-1:0]    nc_q;
  logic [SumW-1:0]    nt_q;
  logic signed [PowerW:0]  dp_q;
  logic [SampleW:0]   adv_q;
  logic               shade_cond_q;

  logic [PowerW:0]    adp;
  logic               at_mpp_cond;
  logic               dp_pos, dp_neg, dv_pos, dv_neg;
  logic signed [RW-1:0] ref_w;
  logic [RefW-1:0]    new_ref;
  logic               new_mpp, new_sh;

  logic [RefW-1:0]    res_ref_q;
  logic               res_mpp_q;
  logic               res_sh_q;

  logic               over_q;
  logic [PowerW-1:0]  sum_scaled;
  logic [PowerW-1:0]  sum_diff;
  logic               over_d;
  logic [NeedW-1:0]   need_d;
  logic               div_start;
  logic               div_done;
  logic [NeedW-1:0]   base;
  logic [CW-1:0]      extra;
  logic [NeedW-1:0]   dec;
  logic [RefW-1:0]    adj_ref;

  assign accept    = in_if.valid && in_ready;
  assign idx_last  = (CW'(idx_q) == (n_q - CW'(1)));
  assign slot_free = !out_valid_q || out_if.ready;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    wr_addr   = IW'(p_q);
    wr_data   = '0;
    out_load  = 1'b0;
    ld_panel  = p_q;
    ld_ref    = res_ref_q;
    ld_we     = 1'b1;
    ld_mpp    = res_mpp_q;
    ld_sh     = res_sh_q;
    ld_last   = 1'b1;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        idx_d    = '0;
        if (accept) begin
          if (6'(in_if.panel_index) >= 6'(MAX_PANELS)) begin
            state_d = S_IDLE;
          end else if (in_if.op == OpInit) begin
            state_d = S_RDP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (idx_last) begin
          state_d = S_RDP;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_RDP: begin
        rd_en   = 1'b1;
        rd_addr = IW'(p_q);
        state_d = (op_q == OpInit) ? S_INIT_WR : S_CALC1;
      end
      S_INIT_WR: begin
        ld_ref = dref_q;
        ld_we  = 1'b0;
        ld_mpp = 1'b0;
        ld_sh  = 1'b0;
        if (slot_free) begin
          wr_en    = 1'b1;
          wr_data  = '{volt: v_q, curr: c_q, mpp: 1'b0, shade: 1'b0, refv: rd_data.refv};
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_CALC1: state_d = S_CALC2;
      S_CALC2: state_d = S_CALC3;
      S_CALC3: begin
        wr_en   = 1'b1;
        wr_data = '{volt: v_q, curr: c_q, mpp: new_mpp, shade: new_sh, refv: new_ref};
        idx_d   = '0;
        state_d = eor_q ? S_RSCAN : S_EMIT0;
      end
      S_RSCAN: begin
        rd_en = 1'b1;
        if (idx_last) begin
          state_d = S_RWAIT;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_RWAIT: state_d = S_NEED;
      S_NEED: begin
        div_start = over_d;
        state_d   = over_d ? S_DIV : S_EMIT0;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_EMIT0;
        end
      end
      S_EMIT0: begin
        ld_last = !over_q;
        idx_d   = '0;
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = over_q ? S_ADJ_RD : S_IDLE;
        end
      end
      S_ADJ_RD: begin
        rd_en   = 1'b1;
        state_d = S_ADJ_WR;
      end
      S_ADJ_WR: begin
        wr_addr  = idx_q;
        wr_data  = rd_data;
        wr_data.refv = adj_ref;
        ld_panel = PanelW'(idx_q);
        ld_ref   = adj_ref;
        ld_mpp   = rd_data.mpp;
        ld_sh    = rd_data.shade;
        ld_last  = idx_last;
        if (slot_free) begin
          wr_en    = 1'b1;
          out_load = 1'b1;
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_ADJ_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      acc_en_q <= 1'b0;
      over_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      acc_en_q <= (state_q == S_SCAN) || (state_q == S_RSCAN);
      if (state_q == S_NEED) begin
        over_q <= over_d;
      end else if (state_q == S_CALC3) begin
        over_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_if.op;
      p_q    <= in_if.panel_index;
      v_q    <= in_if.voltage_raw;
      c_q    <= in_if.current_raw;
      dref_q <= in_if.device_reference;
      eor_q  <= in_if.end_of_round;
      n_q    <= n_active;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_ref_q <= (state_q == S_RSCAN);
    if (state_q == S_IDLE || state_q == S_CALC3) begin
      acc_q     <= '0;
      all_mpp_q <= 1'b1;
    end else if (acc_en_q) begin
      if (acc_ref_q) begin
        acc_q <= acc_q + SumW'(rd_data.refv);
      end else begin
        acc_q     <= acc_q + SumW'(rd_data.curr);
        all_mpp_q <= all_mpp_q & rd_data.mpp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC1) begin
      rec_q      <= rd_data;
      prod_new_q <= v_q * c_q;
      prod_old_q <= rd_data.volt * rd_data.curr;
      dv_q       <= $signed({1'b0, v_q}) - $signed({1'b0, rd_data.volt});
      nc_q       <= SumW'(c_q) * SumW'(n_q);
      nt_q       <= SumW'(curr_thr_q) * SumW'(n_q);
    end
    if (state_q == S_CALC2) begin
      dp_q         <= $signed({1'b0, prod_new_q}) - $signed({1'b0, prod_old_q});
      adv_q        <= dv_q[SampleW] ? (SampleW + 1)'(-dv_q) : (SampleW + 1)'(dv_q);
      shade_cond_q <= {1'b0, acc_q} > ({1'b0, nc_q} + {1'b0, nt_q});
    end
    if (state_q == S_CALC3) begin
      res_ref_q <= new_ref;
      res_mpp_q <= new_mpp;
      res_sh_q  <= new_sh;
    end
  end

  assign adp    = dp_q[PowerW] ? (PowerW + 1)'(-dp_q) : (PowerW + 1)'(dp_q);
  assign dp_pos = !dp_q[PowerW] && (dp_q != '0);
  assign dp_neg = dp_q[PowerW];
  assign dv_pos = !dv_q[SampleW] && (dv_q != '0);
  assign dv_neg = dv_q[SampleW];
  assign at_mpp_cond = (adp < {1'b0, power_thr_q}) && (adv_q < {1'b0, volt_thr_q});

  always_comb begin
    ref_w   = $signed(RW'(dref_q));
    new_mpp = rec_q.mpp;
    new_sh  = rec_q.shade;
    priority if (rec_q.shade) begin
      if (dv_q > $signed(release_thr_q)) begin
        new_sh  = 1'b0;
        new_mpp = 1'b0;
      end else begin
        ref_w = ref_w + $signed(RW'(REF_STEP));
      end
    end else if (at_mpp_cond) begin
      new_mpp = 1'b1;
      if (all_mpp_q && shade_cond_q) begin
        new_sh = 1'b1;
      end
    end else if ((dp_pos && dv_pos) || (dp_neg && dv_neg)) begin
      ref_w   = ref_w + $signed(RW'(REF_STEP));
      new_mpp = 1'b0;
    end else if ((dp_pos && dv_neg) || (dp_neg && dv_pos)) begin
      ref_w   = ref_w - $signed(RW'(REF_STEP));
      new_mpp = 1'b0;
    end else begin
      new_mpp = rec_q.mpp;
    end
    if (ref_w < 0) begin
      new_ref = '0;
    end else if (ref_w > $signed(RW'(RefMax))) begin
      new_ref = RefMax;
    end else begin
      new_ref = RefW'(ref_w);
    end
  end

  assign sum_scaled = PowerW'({acc_q, 8'h00});
  assign over_d     = sum_scaled > PowerW'(ref_limit_q);
  assign sum_diff   = sum_scaled - PowerW'(ref_limit_q);
  assign need_d     = NeedW'(sum_diff[PowerW-1:8]) + NeedW'(1);

  mpphc_div #(
    .DW (CW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (need_d),
    .divisor_i   (n_q),
    .quotient_o  (base),
    .remainder_o (extra),
    .done_o      (div_done)
  );

  assign dec     = base + ((CW'(idx_q) < extra) ? NeedW'(1) : NeedW'(0));
  assign adj_ref = (NeedW'(rd_data.refv) > dec) ? RefW'(NeedW'(rd_data.refv) - dec) : '0;

  mpphc_mem #(
    .DEPTH (MAX_PANELS),
    .AW    (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  logic [PanelW-1:0] out_panel_q;
  logic [RefW-1:0]   out_ref_q;
  logic              out_we_q;
  logic              out_mpp_q;
  logic              out_sh_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_panel_q <= ld_panel;
      out_ref_q   <= ld_ref;
      out_we_q    <= ld_we;
      out_mpp_q   <= ld_mpp;
      out_sh_q    <= ld_sh;
      out_last_q  <= ld_last;
    end
  end

  assign in_if.ready            = in_ready;
  assign out_if.valid           = out_valid_q;
  assign out_if.out_panel       = out_panel_q;
  assign out_if.reference_value = out_ref_q;
  assign out_if.write_enable    = out_we_q;
  assign out_if.at_mpp          = out_mpp_q;
  assign out_if.shaded          = out_sh_q;
  assign out_if.last            = out_last_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside of the divide state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_if.ready))
    else $error("result register overwritten while a beat is pending");

  a_adj_only_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADJ_WR |-> over_q)
    else $error("reduction pass entered without a sum overflow");

  a_adj_never_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADJ_WR && wr_en) |-> adj_ref <= rd_data.refv)
    else $error("reduction raised a reference");

endmodule

@@ tb/tb_multi_panel_mppt_hill_climb.sv @@
module tb_multi_panel_mppt_hill_climb;
  import mpphc_pkg::*;

  localparam int NPanels      = MaxPanelsDefault;
  localparam int Step         = RefStepDefault;
  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 64;

  typedef struct packed {
    logic               op;
    logic [PanelW-1:0]  panel;
    logic [SampleW-1:0] volt;
    logic [SampleW-1:0] curr;
    logic [RefW-1:0]    dref;
    logic               eor;
    logic               drain_first;
  } sample_t;

  typedef struct packed {
    logic [PanelW-1:0] panel;
    logic [RefW-1:0]   refv;
    logic              we;
    logic              mpp;
    logic              shade;
    logic              last;
  } ref_write_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  mpphc_in_if  in_ch ();
  mpphc_out_if out_ch ();

  multi_panel_mppt_hill_climb dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  sample_t    samples_to_send[$];
  ref_write_t due_writes[$];
  sample_t    on_wire;
  int         failures;
  int         cycles;
  int         burst_left;
  int         gap_left;
  int         stall_pct;
  int         stall_span;

  logic [NumW-1:0]            trk_num;
  logic [SampleW-1:0]         trk_vthr;
  logic [PowerW-1:0]          trk_pthr;
  logic [SampleW-1:0]         trk_cthr;
  logic signed [ReleaseW-1:0] trk_rel;
  logic [LimitW-1:0]          trk_limit;
  logic [SampleW-1:0]         trk_volt[NPanels];
  logic [SampleW-1:0]         trk_curr[NPanels];
  bit                         trk_mpp[NPanels];
  bit                         trk_shade[NPanels];
  logic [RefW-1:0]            trk_ref[NPanels];

  int gen_v[NPanels];
  int gen_c[NPanels];

  always #5 clk_i = ~clk_i;

  function automatic int panels_in_use();
    if (trk_num == 0) return 1;
    if (trk_num > NPanels) return NPanels;
    return int'(trk_num);
  endfunction

  task automatic log_write(input int p, input logic [RefW-1:0] refv, input bit we,
                           input bit mpp, input bit shade, input bit last);
    ref_write_t w;
    w.panel = p[PanelW-1:0];
    w.refv  = refv;
    w.we    = we;
    w.mpp   = mpp;
    w.shade = shade;
    w.last  = last;
    due_writes.push_back(w);
  endtask

  task automatic hill_climb_step(input sample_t s);
    int n, p, i;
    longint vn, cn, vo, co, dv, dp, adv, adp, r, isum, rel, lhs, rhs, thr;
    longint unsigned rsum, need, base, extra, dec;
    bit mpp, sh, all_mpp, over;
    n = panels_in_use();
    p = int'(s.panel);
    if (s.op == OpInit) begin
      trk_volt[p]  = s.volt;
      trk_curr[p]  = s.curr;
      trk_mpp[p]   = 1'b0;
      trk_shade[p] = 1'b0;
      log_write(p, s.dref, 1'b0, 1'b0, 1'b0, 1'b1);
      return;
    end
    vn  = s.volt;
    cn  = s.curr;
    vo  = trk_volt[p];
    co  = trk_curr[p];
    dv  = vn - vo;
    dp  = vn * cn - vo * co;
    adv = (dv < 0) ? -dv : dv;
    adp = (dp < 0) ? -dp : dp;
    r   = s.dref;
    rel = trk_rel;
    mpp = trk_mpp[p];
    sh  = trk_shade[p];
    lhs = trk_pthr;
    rhs = trk_vthr;
    if (sh) begin
      if (dv > rel) begin
        sh  = 1'b0;
        mpp = 1'b0;
      end else begin
        r = r + Step;
      end
    end else if (adp < lhs && adv < rhs) begin
      mpp = 1'b1;
      all_mpp = 1'b1;
      for (i = 0; i < n; i++) begin
        if (!trk_mpp[i]) all_mpp = 1'b0;
      end
      if (all_mpp) begin
        isum = 0;
        for (i = 0; i < n; i++) isum = isum + trk_curr[i];
        thr = trk_cthr;
        lhs = isum - n * cn;
        rhs = n * thr;
        if (lhs > rhs) sh = 1'b1;
      end
    end else if ((dp > 0 && dv > 0) || (dp < 0 && dv < 0)) begin
      r = r + Step;
      mpp = 1'b0;
    end else if ((dp > 0 && dv < 0) || (dp < 0 && dv > 0)) begin
      r = r - Step;
      mpp = 1'b0;
    end
    if (r < 0) r = 0;
    if (r > RefMax) r = RefMax;
    trk_volt[p]  = s.volt;
    trk_curr[p]  = s.curr;
    trk_mpp[p]   = mpp;
    trk_shade[p] = sh;
    trk_ref[p]   = r[RefW-1:0];

    over = 1'b0;
    need = 0;
    if (s.eor) begin
      rsum = 0;
      for (i = 0; i < n; i++) rsum = rsum + trk_ref[i];
      if (rsum * 256 > trk_limit) begin
        over = 1'b1;
        need = 1 + (rsum * 256 - trk_limit) / 256;
      end
    end
    log_write(p, trk_ref[p], 1'b1, trk_mpp[p], trk_shade[p], !over);
    if (over) begin
      base  = need / n;
      extra = need % n;
      for (i = 0; i < n; i++) begin
        dec = base + ((i < extra) ? 1 : 0);
        if (trk_ref[i] > dec) trk_ref[i] = trk_ref[i] - dec;
        else trk_ref[i] = '0;
      end
      for (i = 0; i < n; i++) begin
        log_write(i, trk_ref[i], 1'b1, trk_mpp[i], trk_shade[i], i == n - 1);
      end
    end
  endtask

  task automatic queue_sample(input logic op, input int p, input int v, input int c,
                              input int dref, input logic eor, input logic drain);
    sample_t s;
    s.op          = op;
    s.panel       = p[PanelW-1:0];
    s.volt        = v[SampleW-1:0];
    s.curr        = c[SampleW-1:0];
    s.dref        = dref[RefW-1:0];
    s.eor         = eor;
    s.drain_first = drain;
    samples_to_send.push_back(s);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_registers(input int np, input int vthr, input longint pthr,
                               input int cthr, input int rel, input int limit);
    write_reg(CfgNumPanels, 32'(np));
    write_reg(CfgVoltThr, 32'(vthr));
    write_reg(CfgPowerThr, 32'(pthr));
    write_reg(CfgCurrThr, 32'(cthr));
    write_reg(CfgReleaseThr, 32'(rel) & 32'h1FFFF);
    write_reg(CfgRefSumLimit, 32'(limit));
    trk_num   = np[NumW-1:0];
    trk_vthr  = vthr[SampleW-1:0];
    trk_pthr  = pthr[PowerW-1:0];
    trk_cthr  = cthr[SampleW-1:0];
    trk_rel   = rel[ReleaseW-1:0];
    trk_limit = limit[LimitW-1:0];
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (samples_to_send.size() != 0 || in_ch.valid || due_writes.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic int clamp16(input int x);
    if (x < 0) return 0;
    if (x > 65535) return 65535;
    return x;
  endfunction

  function automatic int pick_dref();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 2047;
      2: return $urandom_range(0, 7);
      3: return $urandom_range(2040, 2047);
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  task automatic queue_random_phase(input int quota);
    int  made, n, p, kind;
    bit  drain_placed;
    n = panels_in_use();
    made = 0;
    drain_placed = 1'b0;
    for (p = 0; p < n; p++) begin
      gen_v[p] = $urandom_range(1000, 4000);
      gen_c[p] = $urandom_range(200, 3000);
      queue_sample(OpInit, p, gen_v[p], gen_c[p], pick_dref(), 1'b0, 1'b0);
      made++;
    end
    while (made < quota) begin
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        for (p = 0; p < n; p++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
              gen_v[p] = clamp16(gen_v[p] + int'($urandom_range(0, 8)) - 4);
              gen_c[p] = clamp16(gen_c[p] + int'($urandom_range(0, 8)) - 4);
            end
            6, 7: begin
              gen_v[p] = clamp16(gen_v[p] + int'($urandom_range(0, 600)) - 300);
              gen_c[p] = clamp16(gen_c[p] + int'($urandom_range(0, 600)) - 300);
            end
            8: begin
              gen_v[p] = $urandom_range(0, 65535);
              gen_c[p] = $urandom_range(0, 65535);
            end
            default: gen_c[p] = gen_c[p] / 4;
          endcase
          queue_sample(OpUpdate, p, gen_v[p], gen_c[p], pick_dref(), p == n - 1,
                       !drain_placed && made >= quota / 2);
          if (made >= quota / 2) drain_placed = 1'b1;
          made++;
        end
      end else if (kind < 17) begin
        p = $urandom_range(0, NPanels - 1);
        gen_v[p] = $urandom_range(0, 65535);
        gen_c[p] = $urandom_range(0, 65535);
        queue_sample(OpInit, p, gen_v[p], gen_c[p], pick_dref(), $urandom_range(0, 1), 1'b0);
        made++;
      end else begin
        queue_sample($urandom_range(0, 1), $urandom_range(0, NPanels - 1),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 2047), $urandom_range(0, 1), 1'b0);
        made++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) hill_climb_step(on_wire);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (samples_to_send.size() != 0 &&
                     !(samples_to_send[0].drain_first && due_writes.size() != 0)) begin
          on_wire = samples_to_send.pop_front();
          in_ch.valid            <= 1'b1;
          in_ch.op               <= on_wire.op;
          in_ch.panel_index      <= on_wire.panel;
          in_ch.voltage_raw      <= on_wire.volt;
          in_ch.current_raw      <= on_wire.curr;
          in_ch.device_reference <= on_wire.dref;
          in_ch.end_of_round     <= on_wire.eor;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    ref_write_t got, want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.panel = out_ch.out_panel;
        got.refv  = out_ch.reference_value;
        got.we    = out_ch.write_enable;
        got.mpp   = out_ch.at_mpp;
        got.shade = out_ch.shaded;
        got.last  = out_ch.last;
        if (due_writes.size() == 0) begin
          if (failures < 10)
            $display("unexpected beat: panel %0d ref %0d we %0b mpp %0b shade %0b last %0b",
                     got.panel, got.refv, got.we, got.mpp, got.shade, got.last);
          failures++;
        end else begin
          want = due_writes.pop_front();
          if (got !== want) begin
            if (failures < 10)
              $display({"mismatch (exp/got): panel %0d/%0d ref %0d/%0d we %0b/%0b ",
                        "mpp %0b/%0b shade %0b/%0b last %0b/%0b"},
                       want.panel, got.panel, want.refv, got.refv, want.we, got.we,
                       want.mpp, got.mpp, want.shade, got.shade, want.last, got.last);
            failures++;
          end
        end
      end
      if (stall_span > 0) begin
        stall_span--;
      end else begin
        stall_span = $urandom_range(16, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int i;
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_ch.valid            = 1'b0;
    in_ch.op               = 1'b0;
    in_ch.panel_index      = '0;
    in_ch.voltage_raw      = '0;
    in_ch.current_raw      = '0;
    in_ch.device_reference = '0;
    in_ch.end_of_round     = 1'b0;
    out_ch.ready           = 1'b0;
    failures   = 0;
    cycles     = 0;
    burst_left = 0;
    gap_left   = 0;
    stall_pct  = 0;
    stall_span = 0;
    trk_num   = 1;
    trk_vthr  = '0;
    trk_pthr  = '0;
    trk_cthr  = '0;
    trk_rel   = '0;
    trk_limit = 24'hFFFFFF;
    for (i = 0; i < NPanels; i++) begin
      trk_volt[i]  = '0;
      trk_curr[i]  = '0;
      trk_mpp[i]   = 1'b0;
      trk_shade[i] = 1'b0;
      trk_ref[i]   = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_registers(4, 64, 200000, 100, 20, 16777215);
    queue_sample(OpInit, 0, 2000, 1000, 500, 1'b0, 1'b0);
    queue_sample(OpInit, 1, 2000, 1000, 0, 1'b0, 1'b0);
    queue_sample(OpInit, 2, 65535, 65535, 2047, 1'b0, 1'b0);
    queue_sample(OpInit, 3, 0, 0, 1024, 1'b1, 1'b0);
    queue_sample(OpUpdate, 0, 2100, 1010, 500, 1'b0, 1'b0);
    queue_sample(OpUpdate, 1, 1900, 1100, 4, 1'b0, 1'b0);
    queue_sample(OpUpdate, 2, 65535, 65535, 2047, 1'b0, 1'b0);
    queue_sample(OpUpdate, 3, 1000, 1000, 2045, 1'b0, 1'b0);
    queue_sample(OpUpdate, 0, 2101, 1010, 508, 1'b0, 1'b0);
    queue_sample(OpUpdate, 1, 1901, 1100, 0, 1'b0, 1'b0);
    queue_sample(OpUpdate, 3, 1001, 1000, 2047, 1'b0, 1'b0);
    queue_sample(OpUpdate, 0, 2101, 1010, 508, 1'b0, 1'b0);
    queue_sample(OpUpdate, 0, 2110, 1010, 508, 1'b0, 1'b0);
    queue_sample(OpUpdate, 0, 2200, 1010, 516, 1'b0, 1'b0);
    queue_sample(OpUpdate, 1, 1901, 2000, 0, 1'b1, 1'b0);
    wait_idle();

    set_registers(4, 64, 200000, 100, 20, 25600);
    queue_sample(OpUpdate, 3, 1101, 1100, 2047, 1'b1, 1'b0);
    queue_sample(OpInit, 5, 300, 400, 77, 1'b1, 1'b0);
    queue_sample(OpUpdate, 7, 65535, 0, 2047, 1'b1, 1'b0);
    queue_sample(OpUpdate, 1, 0, 65535, 1, 1'b1, 1'b1);
    queue_sample(OpUpdate, 2, 40000, 30000, 1500, 1'b1, 1'b0);
    wait_idle();

    set_registers(8, 64, 131072, 256, 16, 16777215);
    queue_random_phase(45);
    wait_idle();
    set_registers(0, 0, 0, 0, -65535, 0);
    queue_random_phase(40);
    wait_idle();
    set_registers(15, 65535, 64'hFFFFFFFF, 65535, 65535, $urandom_range(0, 2000000));
    queue_random_phase(40);
    wait_idle();
    set_registers(3, $urandom_range(1, 200), $urandom_range(1000, 500000),
                  $urandom_range(0, 2000), int'($urandom_range(0, 100)) - 50,
                  $urandom_range(0, 2000000));
    queue_random_phase(40);
    wait_idle();
    set_registers(8, $urandom_range(8, 128), $urandom_range(10000, 300000),
                  $urandom_range(0, 500), int'($urandom_range(0, 200)) - 100,
                  $urandom_range(1000000, 4200000));
    queue_random_phase(45);
    wait_idle();
    set_registers(5, $urandom_range(4, 100), $urandom_range(5000, 200000),
                  $urandom_range(0, 300), int'($urandom_range(0, 60)) - 30,
                  $urandom_range(200000, 3000000));
    queue_random_phase(40);
    wait_idle();

    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mpphc_pkg.sv
rtl/core/mpphc_in_if.sv
rtl/core/mpphc_out_if.sv
rtl/core/mpphc_mem.sv
rtl/core/mpphc_div.sv
rtl/core/multi_panel_mppt_hill_climb.sv
tb/tb_multi_panel_mppt_hill_climb.sv
